### src/kap_pkg.sv
// ----------------------------------------------------------------------------
// kap_pkg: keepalive ping monitor definitions
// Event and verdict codes, register indexes, reset values and helpers.
// ----------------------------------------------------------------------------
package kap_pkg;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_PING  = 2'd1,
        KIND_ACK   = 2'd2,
        KIND_RESET = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        VERDICT_NONE = 2'd0,
        VERDICT_SEND = 2'd1,
        VERDICT_LOST = 2'd2
    } verdict_t;

    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_BROKER_MODE         = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIRECT_IDLE_PERIOD  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BROKER_MISS_LIMIT   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIRECT_WAIT_WINDOWS = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIRECT_MISS_LIMIT   = 3'd4;

    localparam logic [7:0] RST_DIRECT_IDLE_PERIOD  = 8'd75;
    localparam logic [7:0] RST_BROKER_MISS_LIMIT   = 8'd4;
    localparam logic [7:0] RST_DIRECT_WAIT_WINDOWS = 8'd3;
    localparam logic [7:0] RST_DIRECT_MISS_LIMIT   = 8'd2;

    // broker idle period follows the direct period setting
    localparam logic [7:0] DIRECT_PERIOD_LONG  = 8'd90;
    localparam logic [7:0] BROKER_PERIOD_LONG  = 8'd144;
    localparam logic [7:0] BROKER_PERIOD_SHORT = 8'd120;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        logic [7:0] r;
        r = (v == COUNT_MAX) ? COUNT_MAX : v + 8'd1;
        return r;
    endfunction

endpackage

### src/keepalive_ping_monitor.sv
// ----------------------------------------------------------------------------
// keepalive_ping_monitor
// Keepalive supervision for one link session, one event per cycle unless m_axis stalls.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one event per request: tuser = kind (tick, ping sent,
//   acknowledge, session reset), tdata[0] = direct_send_ok.
//   m_axis returns exactly one result per event: tdata[1:0] = verdict,
//   tdata[2] = ack_accepted, upper bits zero.
//   cfg writes one of five registers by index (0 broker_mode, 1 direct idle
//   period, 2 broker miss limit, 3 direct wait windows, 4 direct miss limit);
//   indexes 5..7 are ignored. cfg_ready is always high; write only when idle.
// Timing:
//   An event sits in the input register, is evaluated against the counters
//   and moves to the result register once that is empty or being read;
//   m_axis_tvalid then goes high. Throughput is one event per cycle unless
//   m_axis stalls; it is set by the single counter-update stage between them.
// Reset / stall:
//   rst_n loads the register defaults and clears all counters. When m_axis
//   stalls, the result register holds and the input register still takes one
//   more event; s_axis_tready drops only when both are full.
// ----------------------------------------------------------------------------
module keepalive_ping_monitor
    import kap_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [0] direct_send_ok, [7:1] zero
    input  logic [1:0]             s_axis_tuser,   // [1:0] kind

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [7:0]             m_axis_tdata,   // [1:0] verdict, [2] ack_accepted

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data
);

    // configuration
    logic       broker_mode_reg;
    logic [7:0] direct_idle_period_reg;
    logic [7:0] broker_miss_limit_reg;
    logic [7:0] direct_wait_windows_reg;
    logic [7:0] direct_miss_limit_reg;

    // session counters
    logic [7:0] idle_count_reg, idle_count_next;
    logic [7:0] miss_count_reg, miss_count_next;
    logic [7:0] pending_reg, pending_next;

    // input register
    logic  in_valid_reg;
    kind_t kind_reg;
    logic  send_ok_reg;

    // result register
    logic     out_valid_reg;
    verdict_t verdict_reg, verdict_next;
    logic     ack_reg, ack_next;

    logic       s_fire;
    logic       advance;
    logic [7:0] period;
    logic [7:0] idle_inc;
    logic [7:0] pending_inc;
    logic [7:0] miss_inc;

    assign cfg_ready     = 1'b1;
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, ack_reg, verdict_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            broker_mode_reg         <= 1'b0;
            direct_idle_period_reg  <= RST_DIRECT_IDLE_PERIOD;
            broker_miss_limit_reg   <= RST_BROKER_MISS_LIMIT;
            direct_wait_windows_reg <= RST_DIRECT_WAIT_WINDOWS;
            direct_miss_limit_reg   <= RST_DIRECT_MISS_LIMIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BROKER_MODE:         broker_mode_reg         <= cfg_data[0];
                CFG_DIRECT_IDLE_PERIOD:  direct_idle_period_reg  <= cfg_data;
                CFG_BROKER_MISS_LIMIT:   broker_miss_limit_reg   <= cfg_data;
                CFG_DIRECT_WAIT_WINDOWS: direct_wait_windows_reg <= cfg_data;
                CFG_DIRECT_MISS_LIMIT:   direct_miss_limit_reg   <= cfg_data;
                default:                 ;
            endcase
        end
    end

    assign period = broker_mode_reg
                  ? ((direct_idle_period_reg == DIRECT_PERIOD_LONG)
                     ? BROKER_PERIOD_LONG : BROKER_PERIOD_SHORT)
                  : direct_idle_period_reg;

    assign idle_inc    = idle_count_reg + 8'd1;
    assign pending_inc = sat_inc(pending_reg);
    assign miss_inc    = sat_inc(miss_count_reg);

    always_comb
    begin
        idle_count_next = idle_count_reg;
        miss_count_next = miss_count_reg;
        pending_next    = pending_reg;
        verdict_next    = VERDICT_NONE;
        ack_next        = 1'b0;

        unique case (kind_reg)
            KIND_TICK:
            begin
                if (idle_inc < period)
                begin
                    idle_count_next = idle_inc;
                end
                else
                begin
                    idle_count_next = 8'd0;
                    if (broker_mode_reg)
                    begin
                        verdict_next = (miss_count_reg >= broker_miss_limit_reg)
                                     ? VERDICT_LOST : VERDICT_SEND;
                    end
                    else if (!send_ok_reg)
                    begin
                        // window closed with nothing sent
                        if (pending_inc < direct_wait_windows_reg)
                        begin
                            pending_next = pending_inc;
                        end
                        else
                        begin
                            pending_next    = 8'd0;
                            miss_count_next = miss_inc;
                            verdict_next    = (miss_inc >= direct_miss_limit_reg)
                                            ? VERDICT_LOST : VERDICT_NONE;
                        end
                    end
                    else if (pending_reg == 8'd0)
                    begin
                        verdict_next = VERDICT_SEND;
                    end
                    else if (pending_reg < direct_wait_windows_reg)
                    begin
                        pending_next = pending_inc;
                    end
                    else
                    begin
                        pending_next = 8'd0;
                        verdict_next = (miss_count_reg >= direct_miss_limit_reg)
                                     ? VERDICT_LOST : VERDICT_SEND;
                    end
                end
            end
            KIND_PING:
            begin
                if (!broker_mode_reg)
                begin
                    pending_next = 8'd1;
                end
                miss_count_next = miss_inc;
            end
            KIND_ACK:
            begin
                if (broker_mode_reg)
                begin
                    ack_next = 1'b1;
                end
                else if (pending_reg != 8'd0)
                begin
                    miss_count_next = 8'd0;
                    pending_next    = 8'd0;
                    ack_next        = 1'b1;
                end
            end
            KIND_RESET:
            begin
                idle_count_next = 8'd0;
                miss_count_next = 8'd0;
                pending_next    = 8'd0;
            end
            default:
            begin
                idle_count_next = idle_count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            idle_count_reg <= 8'd0;
            miss_count_reg <= 8'd0;
            pending_reg    <= 8'd0;
        end
        else
        begin
            if (s_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg  <= 1'b1;
                idle_count_reg <= idle_count_next;
                miss_count_reg <= miss_count_next;
                pending_reg    <= pending_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            kind_reg    <= kind_t'(s_axis_tuser);
            send_ok_reg <= s_axis_tdata[0];
        end
        if (advance)
        begin
            verdict_reg <= verdict_next;
            ack_reg     <= ack_next;
        end
    end

    // an accepted acknowledge never carries a tick verdict
    a_ack_no_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(ack_reg && (verdict_reg != VERDICT_NONE)))
        else $error("ack_accepted together with a verdict");

    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3))
        else $error("undefined verdict code");

    a_reset_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (kind_reg == KIND_RESET)) |=>
            (idle_count_reg == 8'd0 && miss_count_reg == 8'd0 && pending_reg == 8'd0))
        else $error("session reset left counters nonzero");

    a_miss_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (miss_count_reg == COUNT_MAX)
            && ((kind_reg == KIND_TICK) || (kind_reg == KIND_PING)))
            |=> (miss_count_reg == COUNT_MAX))
        else $error("miss count wrapped");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled with room available");

endmodule
